@@ hw/rtl/lrt_pkg.sv @@
// ----------------------------------------------------------------------------
// Line resampler package
// Shared widths, register indexes, datapath commands and status for the
// triangle-filter line resampler.
// ----------------------------------------------------------------------------
package lrt_pkg;

	// Line store and tap window geometry.
	localparam int unsigned MAX_LINE   = 4096;
	localparam int unsigned LINE_AW    = 12;
	localparam int unsigned MAX_WINDOW = 64;
	localparam int unsigned WIN_AW     = 6;

	// Field and register widths.
	localparam int unsigned PIX_W  = 24;
	localparam int unsigned POS_W  = 12;
	localparam int unsigned LEN_W  = 13;
	localparam int unsigned FW_W   = 16;
	localparam int unsigned WGT_W  = 17;
	localparam int unsigned TOT_W  = 24;

	// Shared divider widths.
	localparam int unsigned DIV_NUM_W = 40;
	localparam int unsigned DIV_DEN_W = 24;
	localparam int unsigned DIV_CNT_W = 6;

	// Operation codes of an input transaction.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SRC_LEN    = 2'd0,
		REG_RES_LEN    = 2'd1,
		REG_HALF_WIDTH = 2'd2
	} reg_idx_t;

	// Commands from the controller to the datapath.
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_CAPTURE,
		CMD_DIV_C,
		CMD_SAVE_C,
		CMD_DIV_W,
		CMD_SAVE_W,
		CMD_DIV_S,
		CMD_SAVE_S,
		CMD_MAG,
		CMD_BOUNDS,
		CMD_TRIM,
		CMD_INIT,
		CMD_DIST,
		CMD_MUL,
		CMD_WEIGHT,
		CMD_REWIND,
		CMD_DIV_N,
		CMD_MUL_N,
		CMD_ACC,
		CMD_PUBLISH
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic minify;
		logic empty;
		logic last;
		logic total_zero;
		logic div_done;
	} dp_status_t;

endpackage

@@ hw/rtl/lrt_in_if.sv @@
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying load and compute transactions.
// ----------------------------------------------------------------------------
interface lrt_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [11:0] position;
	logic [23:0] in_pixel;

	modport source (output valid, output operation, output position, output in_pixel,
		input ready);
	modport sink (input valid, input operation, input position, input in_pixel,
		output ready);
endinterface

@@ hw/rtl/lrt_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying resampled pixels.
// ----------------------------------------------------------------------------
interface lrt_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] out_pixel;
	logic [11:0] out_index;
	logic        window_clipped;

	modport source (output valid, output out_pixel, output out_index,
		output window_clipped, input ready);
	modport sink (input valid, input out_pixel, input out_index,
		input window_clipped, output ready);
endinterface

@@ hw/rtl/lrt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lrt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/lrt_divider.sv @@
// ----------------------------------------------------------------------------
// Shared iterative divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module lrt_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lrt_pkg::DIV_NUM_W-1:0]   num,
	input  logic [lrt_pkg::DIV_DEN_W-1:0]   den,
	output logic [lrt_pkg::DIV_NUM_W-1:0]   quot,
	output logic                            done
);

	logic [lrt_pkg::DIV_NUM_W-1:0] work_q;
	logic [lrt_pkg::DIV_DEN_W-1:0] den_q;
	logic [lrt_pkg::DIV_DEN_W-1:0] rem_q;
	logic [lrt_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [lrt_pkg::DIV_DEN_W:0]   rem_sh;
	logic [lrt_pkg::DIV_DEN_W:0]   rem_sub;
	logic                          fits;

	// One restoring step: shift in the next numerator bit and try to subtract.
	always_comb begin
		rem_sh  = {rem_q, work_q[lrt_pkg::DIV_NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		fits    = (rem_sh >= {1'b0, den_q});
	end

	// Control of the iteration count and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd40;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			den_q  <= den;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[lrt_pkg::DIV_NUM_W-2:0], fits};
			rem_q  <= fits ? rem_sub[lrt_pkg::DIV_DEN_W-1:0]
				: rem_sh[lrt_pkg::DIV_DEN_W-1:0];
		end
	end

	assign quot = work_q;
	assign done = done_q;

endmodule

@@ hw/rtl/lrt_datapath.sv @@
// ----------------------------------------------------------------------------
// Resampler datapath
// Position mapping, window bounds, weight walk, normalization and pixel sums.
// ----------------------------------------------------------------------------
module lrt_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lrt_pkg::dp_cmd_t     cmd,
	output lrt_pkg::dp_status_t  status,
	input  logic                 in_accept,
	input  logic [11:0]          in_position,
	input  logic [23:0]          in_pixel,
	input  logic [12:0]          cfg_src_len,
	input  logic [12:0]          cfg_res_len,
	input  logic [15:0]          cfg_half_width,
	output logic [23:0]          out_pixel,
	output logic [11:0]          out_index,
	output logic                 out_clipped
);

	// Saturating add of one 8-bit tap product.
	function automatic logic [7:0] sat_add8(input logic [7:0] acc, input logic [7:0] v);
		logic [8:0] s;
		s = {1'b0, acc} + {1'b0, v};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	logic [11:0] pos_q;
	logic [23:0] pix_q;
	logic [12:0] src_q, res_q;
	logic [15:0] f_q;
	logic [23:0] prod_c_q;
	logic [31:0] prod_w_q;
	logic [39:0] c_q;
	logic [32:0] w_q;
	logic [16:0] fscale_q;
	logic [6:0]  win_q;
	logic        clip_q;
	logic [23:0] left_q;
	logic [11:0] right_q;
	logic        empty_q;
	logic [11:0] i_q;
	logic [5:0]  k_q;
	logic [31:0] d_q;
	logic        big_q;
	logic [28:0] t_q;
	logic [23:0] total_q;
	logic [23:0] px_q;
	logic [7:0]  tr_q, tg_q, tb_q;
	logic [7:0]  r_q, g_q, b_q;
	logic [23:0] out_pixel_q;
	logic [11:0] out_index_q;
	logic        out_clip_q;

	logic [12:0] src_eff, res_eff;
	logic [24:0] pc;
	logic [32:0] pw;
	logic        div_start;
	logic [39:0] div_num;
	logic [23:0] div_den;
	logic [39:0] quot;
	logic        div_done;
	logic [33:0] wc;
	logic [18:0] win;
	logic [39:0] cmw;
	logic [23:0] left_b;
	logic [40:0] rsum;
	logic [12:0] srcm1;
	logic [11:0] right_b;
	logic        empty_t;
	logic [12:0] count, excess, half, adv, amax, new_l, new_r;
	logic [39:0] tap, tap_dist;
	logic [48:0] pm;
	logic [15:0] raw;
	logic [24:0] pr, pg, pb;
	logic [16:0] scr_rdata;
	logic [23:0] line_rdata;

	// Effective lengths: zero acts as one, long source lines are capped.
	always_comb begin
		if (cfg_src_len == 13'd0) begin
			src_eff = 13'd1;
		end else if (cfg_src_len > 13'd4096) begin
			src_eff = 13'd4096;
		end else begin
			src_eff = cfg_src_len;
		end
		res_eff = (cfg_res_len == 13'd0) ? 13'd1 : cfg_res_len;
		pc      = {13'd0, pos_q} * {12'd0, src_eff};
		pw      = {13'd0, cfg_half_width, 4'd0} * {20'd0, src_eff};
	end

	// Divider operand selection.
	always_comb begin
		div_start = 1'b1;
		div_num   = '0;
		div_den   = '0;
		case (cmd)
			lrt_pkg::CMD_DIV_C: begin
				div_num = {prod_c_q, 16'd0};
				div_den = {11'd0, res_q};
			end
			lrt_pkg::CMD_DIV_W: begin
				div_num = {8'd0, prod_w_q};
				div_den = {11'd0, res_q};
			end
			lrt_pkg::CMD_DIV_S: begin
				div_num = {11'd0, res_q, 16'd0};
				div_den = {11'd0, src_q};
			end
			lrt_pkg::CMD_DIV_N: begin
				div_num = {7'd0, scr_rdata, 16'd0};
				div_den = total_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	lrt_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (quot),
		.done   (div_done)
	);

	// Window size and raw bounds.
	always_comb begin
		wc      = {1'b0, w_q} + 34'h0FFFF;
		win     = {wc[33:16], 1'b1};
		cmw     = c_q - {7'd0, w_q};
		left_b  = (c_q >= {7'd0, w_q}) ? cmw[39:16] : 24'd0;
		rsum    = {1'b0, c_q} + {8'd0, w_q} + 41'h0FFFF;
		srcm1   = src_q - 13'd1;
		right_b = (rsum[40:16] > {13'd0, srcm1[11:0]}) ? srcm1[11:0] : rsum[27:16];
	end

	// Trimming of a window that spills past its size.
	always_comb begin
		empty_t = left_q > {12'd0, right_q};
		count   = {1'b0, right_q} - {1'b0, left_q[11:0]} + 13'd1;
		excess  = count - {6'd0, win_q};
		half    = {2'd0, srcm1[11:1]};
		amax    = half - {1'b0, left_q[11:0]};
		if ({1'b0, left_q[11:0]} < half) begin
			adv = (amax > excess) ? excess : amax;
		end else begin
			adv = 13'd0;
		end
		new_l = {1'b0, left_q[11:0]} + adv;
		new_r = {1'b0, right_q} - (excess - adv);
	end

	// Tap distance, raw weight and per-channel products.
	always_comb begin
		tap      = {12'd0, i_q, 16'd0};
		tap_dist = (c_q >= tap) ? (c_q - tap) : (tap - c_q);
		pm       = {32'd0, fscale_q} * {17'd0, d_q};
		raw      = (big_q || (t_q >= {13'd0, f_q})) ? 16'd0 : (f_q - t_q[15:0]);
		pr       = {8'd0, quot[16:0]} * {17'd0, px_q[7:0]};
		pg       = {8'd0, quot[16:0]} * {17'd0, px_q[15:8]};
		pb       = {8'd0, quot[16:0]} * {17'd0, px_q[23:16]};
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			pos_q <= in_position;
			pix_q <= in_pixel;
		end
	end

	// Weight total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd == lrt_pkg::CMD_INIT) begin
			total_q <= '0;
		end else if (cmd == lrt_pkg::CMD_WEIGHT) begin
			total_q <= total_q + {8'd0, raw};
		end
	end

	// Datapath registers stepped by the controller.
	always_ff @(posedge clk) begin
		case (cmd)
			lrt_pkg::CMD_CAPTURE: begin
				src_q    <= src_eff;
				res_q    <= res_eff;
				f_q      <= cfg_half_width;
				prod_c_q <= pc[23:0];
				prod_w_q <= pw[31:0];
			end
			lrt_pkg::CMD_SAVE_C: c_q <= quot;
			lrt_pkg::CMD_SAVE_W: w_q <= quot[32:0];
			lrt_pkg::CMD_SAVE_S: fscale_q <= quot[16:0];
			lrt_pkg::CMD_MAG: begin
				w_q      <= {13'd0, f_q, 4'd0};
				fscale_q <= 17'h10000;
			end
			lrt_pkg::CMD_BOUNDS: begin
				clip_q  <= (win > 19'd64);
				win_q   <= (win > 19'd64) ? 7'd64 : win[6:0];
				left_q  <= left_b;
				right_q <= right_b;
			end
			lrt_pkg::CMD_TRIM: begin
				empty_q <= empty_t;
				if (!empty_t && (count > {6'd0, win_q})) begin
					left_q  <= {12'd0, new_l[11:0]};
					right_q <= new_r[11:0];
				end
			end
			lrt_pkg::CMD_INIT: begin
				i_q <= left_q[11:0];
				k_q <= '0;
				r_q <= '0;
				g_q <= '0;
				b_q <= '0;
			end
			lrt_pkg::CMD_DIST: begin
				d_q   <= tap_dist[31:0];
				big_q <= |tap_dist[39:32];
			end
			lrt_pkg::CMD_MUL: t_q <= pm[48:20];
			lrt_pkg::CMD_WEIGHT, lrt_pkg::CMD_ACC: begin
				i_q <= i_q + 12'd1;
				k_q <= k_q + 6'd1;
				if (cmd == lrt_pkg::CMD_ACC) begin
					r_q <= sat_add8(r_q, tr_q);
					g_q <= sat_add8(g_q, tg_q);
					b_q <= sat_add8(b_q, tb_q);
				end
			end
			lrt_pkg::CMD_REWIND: begin
				i_q <= left_q[11:0];
				k_q <= '0;
			end
			lrt_pkg::CMD_DIV_N: px_q <= line_rdata;
			lrt_pkg::CMD_MUL_N: begin
				tr_q <= pr[23:16];
				tg_q <= pg[23:16];
				tb_q <= pb[23:16];
			end
			lrt_pkg::CMD_PUBLISH: begin
				out_pixel_q <= {b_q, g_q, r_q};
				out_index_q <= pos_q;
				out_clip_q  <= clip_q;
			end
			default: ;
		endcase
	end

	// Source line store.
	lrt_ram #(.WIDTH(24), .DEPTH(4096)) u_line (
		.clk   (clk),
		.we    (cmd == lrt_pkg::CMD_LOAD),
		.waddr (pos_q),
		.wdata (pix_q),
		.raddr (i_q),
		.rdata (line_rdata)
	);

	// Raw weight scratch.
	lrt_ram #(.WIDTH(17), .DEPTH(64)) u_scratch (
		.clk   (clk),
		.we    (cmd == lrt_pkg::CMD_WEIGHT),
		.waddr (k_q),
		.wdata ({1'b0, raw}),
		.raddr (k_q),
		.rdata (scr_rdata)
	);

	// Status back to the controller.
	always_comb begin
		status.minify     = res_q < src_q;
		status.empty      = empty_q;
		status.last       = (i_q == right_q);
		status.total_zero = (total_q == 24'd0);
		status.div_done   = div_done;
	end

	assign out_pixel   = out_pixel_q;
	assign out_index   = out_index_q;
	assign out_clipped = out_clip_q;

endmodule

@@ hw/rtl/lrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Resampler controller
// Sequences the datapath through mapping, two window walks and publishing.
// ----------------------------------------------------------------------------
module lrt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_accept,
	input  logic                 in_operation,
	output logic                 in_ready,
	input  logic                 out_ready,
	output logic                 out_valid,
	input  lrt_pkg::dp_status_t  status,
	output lrt_pkg::dp_cmd_t     cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_CAPTURE, S_DIV_C, S_WAIT_C, S_SAVE_C, S_DIV_W, S_WAIT_W, S_SAVE_W,
		S_DIV_S, S_WAIT_S, S_SAVE_S, S_MAG, S_BOUNDS, S_TRIM, S_INIT, S_DIST, S_MUL,
		S_WEIGHT, S_REWIND, S_FETCH, S_DIV_N, S_WAIT_N, S_MUL_N, S_ACC, S_DONE, S_PUB
	} state_t;

	state_t           state_q;
	lrt_pkg::dp_cmd_t cmd_q;
	logic             out_valid_q;

	// State, command and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= lrt_pkg::CMD_NONE;
			out_valid_q <= 1'b0;
		end else begin
			cmd_q <= lrt_pkg::CMD_NONE;
			if (state_q == S_PUB) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (in_operation == lrt_pkg::OP_EMIT) begin
							state_q <= S_CAPTURE;
							cmd_q   <= lrt_pkg::CMD_CAPTURE;
						end else begin
							cmd_q <= lrt_pkg::CMD_LOAD;
						end
					end
				end
				S_CAPTURE: begin
					state_q <= S_DIV_C;
					cmd_q   <= lrt_pkg::CMD_DIV_C;
				end
				S_DIV_C: state_q <= S_WAIT_C;
				S_WAIT_C: begin
					if (status.div_done) begin
						state_q <= S_SAVE_C;
						cmd_q   <= lrt_pkg::CMD_SAVE_C;
					end
				end
				S_SAVE_C: begin
					if (status.minify) begin
						state_q <= S_DIV_W;
						cmd_q   <= lrt_pkg::CMD_DIV_W;
					end else begin
						state_q <= S_MAG;
						cmd_q   <= lrt_pkg::CMD_MAG;
					end
				end
				S_DIV_W: state_q <= S_WAIT_W;
				S_WAIT_W: begin
					if (status.div_done) begin
						state_q <= S_SAVE_W;
						cmd_q   <= lrt_pkg::CMD_SAVE_W;
					end
				end
				S_SAVE_W: begin
					state_q <= S_DIV_S;
					cmd_q   <= lrt_pkg::CMD_DIV_S;
				end
				S_DIV_S: state_q <= S_WAIT_S;
				S_WAIT_S: begin
					if (status.div_done) begin
						state_q <= S_SAVE_S;
						cmd_q   <= lrt_pkg::CMD_SAVE_S;
					end
				end
				S_SAVE_S, S_MAG: begin
					state_q <= S_BOUNDS;
					cmd_q   <= lrt_pkg::CMD_BOUNDS;
				end
				S_BOUNDS: begin
					state_q <= S_TRIM;
					cmd_q   <= lrt_pkg::CMD_TRIM;
				end
				S_TRIM: begin
					state_q <= S_INIT;
					cmd_q   <= lrt_pkg::CMD_INIT;
				end
				S_INIT: begin
					if (status.empty) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIST;
						cmd_q   <= lrt_pkg::CMD_DIST;
					end
				end
				S_DIST: begin
					state_q <= S_MUL;
					cmd_q   <= lrt_pkg::CMD_MUL;
				end
				S_MUL: begin
					state_q <= S_WEIGHT;
					cmd_q   <= lrt_pkg::CMD_WEIGHT;
				end
				S_WEIGHT: begin
					if (status.last) begin
						state_q <= S_REWIND;
						cmd_q   <= lrt_pkg::CMD_REWIND;
					end else begin
						state_q <= S_DIST;
						cmd_q   <= lrt_pkg::CMD_DIST;
					end
				end
				S_REWIND: begin
					if (status.total_zero) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_DIV_N;
					cmd_q   <= lrt_pkg::CMD_DIV_N;
				end
				S_DIV_N: state_q <= S_WAIT_N;
				S_WAIT_N: begin
					if (status.div_done) begin
						state_q <= S_MUL_N;
						cmd_q   <= lrt_pkg::CMD_MUL_N;
					end
				end
				S_MUL_N: begin
					state_q <= S_ACC;
					cmd_q   <= lrt_pkg::CMD_ACC;
				end
				S_ACC: begin
					state_q <= status.last ? S_DONE : S_FETCH;
				end
				S_DONE: begin
					// Wait until the output register is free or being emptied.
					if (!out_valid_q || out_ready) begin
						state_q <= S_PUB;
						cmd_q   <= lrt_pkg::CMD_PUBLISH;
					end
				end
				S_PUB: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd       = cmd_q;

endmodule

@@ hw/rtl/line_resampler_triangle_core.sv @@
// ----------------------------------------------------------------------------
// Triangle-filter line resampler
// Resamples one line of packed RGB pixels with a normalized triangle filter.
// ----------------------------------------------------------------------------
// Usage: program source_length, result_length and filter_half_width over the
// APB port (byte addresses 0, 4, 8) while the block is idle. Then send load
// transactions (operation 0) on the items channel to fill the line store, one
// per cycle, and compute transactions (operation 1) naming a result index.
// Each compute transaction returns one pixel on the results channel; loads
// return nothing.
// A compute transaction first maps the position and sets up the window, with
// one pass of the shared iterative divider when magnifying and three when
// minifying, then walks the taps for the raw weights, rewinds, walks them
// again for normalization, where the divider again sets the pace, and then
// publishes the pixel.
// No new transaction is taken while a compute is in progress.
// A finished pixel sits in an output register; the next transaction is taken
// while it waits, and a stalled receiver only holds back the next publish.
// Reset returns the lengths to 1 and the half width to 1.0; the line store
// holds no defined contents until loaded.
// ----------------------------------------------------------------------------
module line_resampler_triangle_core (
	input  logic        clk,
	input  logic        arst_n,
	lrt_in_if.sink      items,
	lrt_out_if.source   results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [12:0]         src_len_q;
	logic [12:0]         res_len_q;
	logic [15:0]         half_width_q;
	logic                cfg_write;
	logic                in_accept;
	logic                in_ready;
	logic                out_valid;
	lrt_pkg::dp_cmd_t    cmd;
	lrt_pkg::dp_status_t status;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_len_q    <= 13'd1;
			res_len_q    <= 13'd1;
			half_width_q <= 16'd4096;
		end else if (cfg_write) begin
			unique case (lrt_pkg::reg_idx_t'(paddr[3:2]))
				lrt_pkg::REG_SRC_LEN:    src_len_q    <= pwdata[12:0];
				lrt_pkg::REG_RES_LEN:    res_len_q    <= pwdata[12:0];
				lrt_pkg::REG_HALF_WIDTH: half_width_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (lrt_pkg::reg_idx_t'(paddr[3:2]))
			lrt_pkg::REG_SRC_LEN:    prdata = {19'd0, src_len_q};
			lrt_pkg::REG_RES_LEN:    prdata = {19'd0, res_len_q};
			lrt_pkg::REG_HALF_WIDTH: prdata = {16'd0, half_width_q};
			default:                 prdata = 32'd0;
		endcase
	end

	assign in_accept     = items.valid && in_ready;
	assign items.ready   = in_ready;
	assign results.valid = out_valid;

	lrt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_accept    (in_accept),
		.in_operation (items.operation),
		.in_ready     (in_ready),
		.out_ready    (results.ready),
		.out_valid    (out_valid),
		.status       (status),
		.cmd          (cmd)
	);

	lrt_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_accept      (in_accept),
		.in_position    (items.position),
		.in_pixel       (items.in_pixel),
		.cfg_src_len    (src_len_q),
		.cfg_res_len    (res_len_q),
		.cfg_half_width (half_width_q),
		.out_pixel      (results.out_pixel),
		.out_index      (results.out_index),
		.out_clipped    (results.window_clipped)
	);

endmodule
